@@ design/paf_pkg.sv @@
// ----------------------------------------------------------------------------
// paf_pkg
// Shared sizes, status codes and partition entry type of the allocator.
// ----------------------------------------------------------------------------
package paf_pkg;

    localparam int MEM_UNITS = 1024;
    localparam int MAX_PARTS = 64;

    localparam int START_W = $clog2(MEM_UNITS);
    localparam int SIZE_W  = $clog2(MEM_UNITS + 1);
    localparam int IDX_W   = $clog2(MAX_PARTS);
    localparam int CNT_W   = $clog2(MAX_PARTS + 1);
    localparam int CMP_W   = (SIZE_W > 11) ? SIZE_W : 11;

    localparam int OWNER_W = 16;
    localparam int REQ_W   = 11;
    localparam int ADDR_W  = 10;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_NOTASK = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic FIT_FIRST = 1'b0;

    localparam logic REG_FIT_MODE = 1'b0;

    localparam logic [5:0] MIN_LEFTOVER_RST = 6'd5;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
        logic [OWNER_W-1:0] owner;
        logic               busy;
    } ent_t;

    localparam int ENT_W = $bits(ent_t);

    function automatic logic [ADDR_W-1:0] to_addr(input logic [START_W-1:0] s);
        logic [31:0] t;
        t = 32'(s);
        return t[ADDR_W-1:0];
    endfunction

endpackage

@@ design/paf_ram.sv @@
// ----------------------------------------------------------------------------
// paf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module paf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/partition_allocator_first_best_fit.sv @@
// ----------------------------------------------------------------------------
// partition_allocator_first_best_fit
// Variable partition allocator, first fit or best fit, table held in RAM.
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  s_      | in        | cmd, task_id, request_size
//  m_      | out       | status, start_addr
//  apb     | cfg       | fit_mode at 0x0, min_leftover at 0x4
//
// Allocate: scans entries; on a split moves later entries up and writes the tail; writes the head.
// Free: scans entries, checks the neighbours of each released entry and merges free ones,
// moving later entries down on each merge. One table RAM access per cycle; one item at a time.
// After reset the INIT state writes entry 0 before the first transfer.
// A held result stalls only the next completion, not the table work.
// ----------------------------------------------------------------------------
module partition_allocator_first_best_fit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [15:0] s_task_id,
    input  logic [10:0] s_request_size,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [9:0]  m_start_addr,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        INIT, IDLE, A_RD, A_CHK, A_DEC, A_SH_RD, A_SH_WR, A_WR_TAIL, A_WR_HEAD,
        F_RD, F_CHK, F_NCHK, F_MRG, D_RD, D_WR, DONE
    } state_t;

    state_t state_reg;

    logic                        fit_mode_reg;
    logic [5:0]                  min_leftover_reg;

    logic [paf_pkg::CNT_W-1:0]   count_reg;
    logic [paf_pkg::CNT_W-1:0]   k_reg;
    logic [paf_pkg::CNT_W-1:0]   j_reg;
    logic [1:0]                  drop_reg;
    logic [paf_pkg::IDX_W-1:0]   pick_reg;
    paf_pkg::ent_t               pick_ent_reg;
    logic                        found_reg;
    logic                        split_reg;
    logic                        hit_reg;
    paf_pkg::ent_t               prev_reg;
    paf_pkg::ent_t               cur_reg;
    logic                        nfree_reg;
    logic [paf_pkg::SIZE_W-1:0]  nsize_reg;
    logic [paf_pkg::OWNER_W-1:0] task_reg;
    logic [paf_pkg::REQ_W-1:0]   want_reg;
    logic [1:0]                  status_reg;
    logic [paf_pkg::ADDR_W-1:0]  addr_reg;

    logic                        ram_we;
    logic [paf_pkg::IDX_W-1:0]   ram_waddr;
    paf_pkg::ent_t               ram_wdata;
    logic [paf_pkg::IDX_W-1:0]   ram_raddr;
    paf_pkg::ent_t               ram_rdata;

    logic [paf_pkg::CNT_W-1:0]   kp1;
    logic [paf_pkg::CNT_W-1:0]   km1;
    logic [paf_pkg::CNT_W:0]     jd;
    logic [paf_pkg::CMP_W-1:0]   want_c;
    logic                        a_fits;
    logic                        a_take;
    logic                        split_need;
    paf_pkg::ent_t               head_ent;
    paf_pkg::ent_t               tail_ent;
    logic [paf_pkg::SIZE_W-1:0]  msize;
    paf_pkg::ent_t               merged;
    paf_pkg::ent_t               prev_new;
    logic                        prev_merge;
    logic [1:0]                  f_drop;
    logic [paf_pkg::CNT_W-1:0]   f_p;
    logic [paf_pkg::CNT_W:0]     f_pd;
    logic [paf_pkg::CNT_W:0]     jd1;

    paf_ram #(
        .WIDTH (paf_pkg::ENT_W),
        .DEPTH (paf_pkg::MAX_PARTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == paf_pkg::REG_FIT_MODE) ? {31'd0, fit_mode_reg}
                                                          : {26'd0, min_leftover_reg};
    assign s_ready = (state_reg == IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg     <= paf_pkg::FIT_FIRST;
            min_leftover_reg <= paf_pkg::MIN_LEFTOVER_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == paf_pkg::REG_FIT_MODE) begin
                fit_mode_reg <= pwdata[0];
            end else begin
                min_leftover_reg <= pwdata[5:0];
            end
        end
    end

    always_comb begin
        kp1        = paf_pkg::CNT_W'(k_reg + 1'b1);
        km1        = paf_pkg::CNT_W'(k_reg - 1'b1);
        jd         = (paf_pkg::CNT_W+1)'(j_reg) + (paf_pkg::CNT_W+1)'(drop_reg);
        jd1        = jd + 1'b1;
        want_c     = paf_pkg::CMP_W'(want_reg);
        a_fits     = !ram_rdata.busy && (paf_pkg::CMP_W'(ram_rdata.size) >= want_c);
        a_take     = a_fits && ((fit_mode_reg == paf_pkg::FIT_FIRST) || !found_reg ||
                                (ram_rdata.size < pick_ent_reg.size));
        split_need = (paf_pkg::CMP_W'(pick_ent_reg.size) - want_c)
                     > paf_pkg::CMP_W'(min_leftover_reg);

        head_ent       = pick_ent_reg;
        head_ent.size  = split_reg ? paf_pkg::SIZE_W'(want_reg) : pick_ent_reg.size;
        head_ent.owner = task_reg;
        head_ent.busy  = 1'b1;

        tail_ent.start = paf_pkg::START_W'(paf_pkg::CMP_W'(pick_ent_reg.start) + want_c);
        tail_ent.size  = paf_pkg::SIZE_W'(paf_pkg::CMP_W'(pick_ent_reg.size) - want_c);
        tail_ent.owner = '0;
        tail_ent.busy  = 1'b0;

        msize        = cur_reg.size + (nfree_reg ? nsize_reg : '0);
        merged.start = cur_reg.start;
        merged.size  = msize;
        merged.owner = '0;
        merged.busy  = 1'b0;
        prev_new      = prev_reg;
        prev_new.size = prev_reg.size + msize;

        prev_merge = (k_reg != '0) && !prev_reg.busy;
        f_drop     = 2'(prev_merge) + 2'(nfree_reg);
        f_p        = prev_merge ? k_reg : kp1;
        f_pd       = (paf_pkg::CNT_W+1)'(f_p) + (paf_pkg::CNT_W+1)'(f_drop);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        ram_raddr = '0;
        case (state_reg)
            INIT: begin
                ram_we          = 1'b1;
                ram_wdata.start = '0;
                ram_wdata.size  = paf_pkg::SIZE_W'(paf_pkg::MEM_UNITS);
                ram_wdata.owner = '0;
                ram_wdata.busy  = 1'b0;
            end
            A_RD, F_RD: ram_raddr = k_reg[paf_pkg::IDX_W-1:0];
            F_CHK:      ram_raddr = kp1[paf_pkg::IDX_W-1:0];
            A_SH_RD:    ram_raddr = j_reg[paf_pkg::IDX_W-1:0];
            A_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = paf_pkg::IDX_W'(j_reg + 1'b1);
            end
            A_WR_TAIL: begin
                ram_we    = 1'b1;
                ram_waddr = paf_pkg::IDX_W'(pick_reg + 1'b1);
                ram_wdata = tail_ent;
            end
            A_WR_HEAD: begin
                ram_we    = 1'b1;
                ram_waddr = pick_reg;
                ram_wdata = head_ent;
            end
            F_MRG: begin
                ram_we    = 1'b1;
                ram_waddr = prev_merge ? km1[paf_pkg::IDX_W-1:0] : k_reg[paf_pkg::IDX_W-1:0];
                ram_wdata = prev_merge ? prev_new : merged;
            end
            D_RD: ram_raddr = jd[paf_pkg::IDX_W-1:0];
            D_WR: begin
                ram_we    = 1'b1;
                ram_waddr = j_reg[paf_pkg::IDX_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= INIT;
            count_reg <= paf_pkg::CNT_W'(1);
            m_valid   <= 1'b0;
        end else begin
            if (m_ready && state_reg != DONE) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                INIT: state_reg <= IDLE;
                IDLE: begin
                    if (s_valid) begin
                        task_reg  <= s_task_id;
                        want_reg  <= s_request_size;
                        addr_reg  <= '0;
                        k_reg     <= '0;
                        found_reg <= 1'b0;
                        hit_reg   <= 1'b0;
                        if (s_cmd == paf_pkg::CMD_FREE) begin
                            state_reg <= F_RD;
                        end else if (s_request_size == '0) begin
                            status_reg <= paf_pkg::ST_NOFIT;
                            state_reg  <= DONE;
                        end else begin
                            state_reg <= A_RD;
                        end
                    end
                end
                A_RD: state_reg <= A_CHK;
                A_CHK: begin
                    if (a_take) begin
                        pick_reg     <= k_reg[paf_pkg::IDX_W-1:0];
                        pick_ent_reg <= ram_rdata;
                        found_reg    <= 1'b1;
                    end
                    if ((a_take && fit_mode_reg == paf_pkg::FIT_FIRST) || kp1 >= count_reg) begin
                        state_reg <= A_DEC;
                    end else begin
                        k_reg     <= kp1;
                        state_reg <= A_RD;
                    end
                end
                A_DEC: begin
                    if (!found_reg) begin
                        status_reg <= paf_pkg::ST_NOFIT;
                        state_reg  <= DONE;
                    end else if (!split_need) begin
                        split_reg <= 1'b0;
                        state_reg <= A_WR_HEAD;
                    end else if (count_reg >= paf_pkg::CNT_W'(paf_pkg::MAX_PARTS)) begin
                        status_reg <= paf_pkg::ST_FULL;
                        state_reg  <= DONE;
                    end else begin
                        j_reg     <= paf_pkg::CNT_W'(count_reg - 1'b1);
                        state_reg <= (paf_pkg::CNT_W'(count_reg - 1'b1) >
                                      paf_pkg::CNT_W'(pick_reg)) ? A_SH_RD : A_WR_TAIL;
                    end
                end
                A_SH_RD: state_reg <= A_SH_WR;
                A_SH_WR: begin
                    j_reg     <= paf_pkg::CNT_W'(j_reg - 1'b1);
                    state_reg <= (paf_pkg::CNT_W'(j_reg - 1'b1) >
                                  paf_pkg::CNT_W'(pick_reg)) ? A_SH_RD : A_WR_TAIL;
                end
                A_WR_TAIL: begin
                    count_reg <= paf_pkg::CNT_W'(count_reg + 1'b1);
                    split_reg <= 1'b1;
                    state_reg <= A_WR_HEAD;
                end
                A_WR_HEAD: begin
                    status_reg <= paf_pkg::ST_OK;
                    addr_reg   <= paf_pkg::to_addr(pick_ent_reg.start);
                    state_reg  <= DONE;
                end
                F_RD: begin
                    if (k_reg >= count_reg) begin
                        status_reg <= hit_reg ? paf_pkg::ST_OK : paf_pkg::ST_NOTASK;
                        state_reg  <= DONE;
                    end else begin
                        state_reg <= F_CHK;
                    end
                end
                F_CHK: begin
                    if (ram_rdata.busy && ram_rdata.owner == task_reg) begin
                        hit_reg <= 1'b1;
                        cur_reg <= ram_rdata;
                        if (kp1 < count_reg) begin
                            state_reg <= F_NCHK;
                        end else begin
                            nfree_reg <= 1'b0;
                            state_reg <= F_MRG;
                        end
                    end else begin
                        prev_reg  <= ram_rdata;
                        k_reg     <= kp1;
                        state_reg <= F_RD;
                    end
                end
                F_NCHK: begin
                    nfree_reg <= !ram_rdata.busy;
                    nsize_reg <= ram_rdata.size;
                    state_reg <= F_MRG;
                end
                F_MRG: begin
                    prev_reg <= prev_merge ? prev_new : merged;
                    if (!prev_merge) begin
                        k_reg <= kp1;
                    end
                    j_reg    <= f_p;
                    drop_reg <= f_drop;
                    if (f_drop == 2'd0) begin
                        state_reg <= F_RD;
                    end else if (f_pd < (paf_pkg::CNT_W+1)'(count_reg)) begin
                        state_reg <= D_RD;
                    end else begin
                        count_reg <= paf_pkg::CNT_W'(count_reg - f_drop);
                        state_reg <= F_RD;
                    end
                end
                D_RD: state_reg <= D_WR;
                D_WR: begin
                    j_reg <= paf_pkg::CNT_W'(j_reg + 1'b1);
                    if (jd1 < (paf_pkg::CNT_W+1)'(count_reg)) begin
                        state_reg <= D_RD;
                    end else begin
                        count_reg <= paf_pkg::CNT_W'(count_reg - drop_reg);
                        state_reg <= F_RD;
                    end
                end
                DONE: begin
                    if (!m_valid || m_ready) begin
                        m_valid      <= 1'b1;
                        m_status     <= status_reg;
                        m_start_addr <= addr_reg;
                        state_reg    <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

@@ design/paf_checker.sv @@
// ----------------------------------------------------------------------------
// paf_checker
// Port-level checks of the partition allocator, bound to the top level.
// ----------------------------------------------------------------------------
module paf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_status,
    input logic [9:0] m_start_addr
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_start_addr))
        else $error("result changed while stalled");

    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != paf_pkg::ST_OK |-> m_start_addr == '0)
        else $error("start address set on failed request");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer taken while busy");

    a_result_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without a pending request");

endmodule

bind partition_allocator_first_best_fit paf_checker u_paf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_start_addr (m_start_addr)
);
